>>> rtl/vn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths, reset values and types for the vector normalization pipeline.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int VEC_W       = 32;           // Q16.16 component
  localparam int MAG_W       = VEC_W;        // magnitude of a component
  localparam int SQ_W        = 2 * MAG_W;    // square, and the sum of squares
  localparam int ROOT_W      = SQ_W / 2;     // length
  localparam int REM_W       = ROOT_W + 2;   // square root remainder
  localparam int UNIT_W      = 16;           // Q1.15 result
  localparam int FRAC_SH     = UNIT_W - 1;   // numerator shift
  localparam int NUM_W       = MAG_W + FRAC_SH; // numerator and division remainder
  localparam int QUO_W       = UNIT_W;       // quotient bits, top one flags saturation
  localparam int MIN_W       = 16;
  localparam int LANES       = 3;

  localparam logic [MIN_W-1:0]  MIN_MAG_RESET = MIN_W'(1);
  localparam logic [UNIT_W-1:0] UNIT_MAX      = UNIT_W'(32767);

  // what travels beside the square root
  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [LANES-1:0]            neg;
  } sqrt_side_t;

  // what travels beside the divider
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             too_small;
  } div_side_t;

endpackage
`default_nettype wire

>>> rtl/vector3_normalize.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_normalize
// Normalizes a signed Q16.16 three-component vector to a signed Q1.15 unit
// vector.
//
// A request is taken at a rising edge with start high and busy low; busy is
// always low, so a new request may be issued every cycle.
// Each result shows on unit_x, unit_y, unit_z and too_small for one cycle,
// marked by done. The receiver cannot stall the results. Throughput is one
// vector per cycle. The pipeline is: input register, three 32x32 squares,
// two add stages, a 32-stage square root with one root bit per stage, a
// numerator stage, a 16-stage restoring divider shared by the three lanes,
// and an output register.
// min_magnitude is written through cfg_valid/cfg_ready/cfg_data (cfg_ready is
// always high) and must only change while no request is in flight.
// too_small is high, with zero components, when the length does not exceed it.
// Reset clears all valid bits and sets min_magnitude to 1.
// ----------------------------------------------------------------------------
module vector3_normalize
  import vn_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [VEC_W-1:0]  vec_x,
  input  wire logic signed [VEC_W-1:0]  vec_y,
  input  wire logic signed [VEC_W-1:0]  vec_z,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [MIN_W-1:0]         cfg_data,
  output logic                          done,
  output logic signed [UNIT_W-1:0]      unit_x,
  output logic signed [UNIT_W-1:0]      unit_y,
  output logic signed [UNIT_W-1:0]      unit_z,
  output logic                          too_small
);

  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;

  logic [MIN_W-1:0] min_magnitude;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_magnitude <= MIN_MAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_magnitude <= cfg_data;
    end
  end

  // stage 1: magnitudes
  logic                         s1_valid;
  sqrt_side_t                   s1_side;
  logic [LANES-1:0][VEC_W-1:0]  in_vec;

  assign in_vec = {vec_z, vec_y, vec_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    for (int i = 0; i < LANES; i++) begin
      s1_side.neg[i] <= in_vec[i][VEC_W-1];
      s1_side.mag[i] <= in_vec[i][VEC_W-1] ? (~in_vec[i] + MAG_W'(1)) : in_vec[i];
    end
  end

  // stage 2: squares
  logic                        s2_valid;
  sqrt_side_t                  s2_side;
  logic [LANES-1:0][SQ_W-1:0]  s2_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_side <= s1_side;
    for (int i = 0; i < LANES; i++) begin
      s2_sq[i] <= SQ_W'(s1_side.mag[i]) * SQ_W'(s1_side.mag[i]);
    end
  end

  // stages 3 and 4: sum of squares, fits in 64 bits
  logic             s3_valid, s4_valid;
  sqrt_side_t       s3_side, s4_side;
  logic [SQ_W-1:0]  s3_sum, s3_z, s4_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
    s3_side <= s2_side;
    s3_sum  <= s2_sq[0] + s2_sq[1];
    s3_z    <= s2_sq[2];
    s4_side <= s3_side;
    s4_sum  <= s3_sum + s3_z;
  end

  // square root chain
  logic              sq_valid [0:SQRT_STEPS];
  logic [SQ_W-1:0]   sq_op    [0:SQRT_STEPS];
  logic [REM_W-1:0]  sq_rem   [0:SQRT_STEPS];
  logic [ROOT_W-1:0] sq_root  [0:SQRT_STEPS];
  sqrt_side_t        sq_side  [0:SQRT_STEPS];

  assign sq_valid[0] = s4_valid;
  assign sq_op[0]    = s4_sum;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = s4_side;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    vn_sqrt_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid[g]),
      .in_op     (sq_op[g]),
      .in_rem    (sq_rem[g]),
      .in_root   (sq_root[g]),
      .in_side   (sq_side[g]),
      .out_valid (sq_valid[g+1]),
      .out_op    (sq_op[g+1]),
      .out_rem   (sq_rem[g+1]),
      .out_root  (sq_root[g+1]),
      .out_side  (sq_side[g+1])
    );
  end

  // numerator stage: |c| * 2^15 + len/2, threshold check
  logic [ROOT_W-1:0] len;
  sqrt_side_t        len_side;

  assign len      = sq_root[SQRT_STEPS];
  assign len_side = sq_side[SQRT_STEPS];

  logic                        dv_valid [0:DIV_STEPS];
  logic [ROOT_W-1:0]           dv_len   [0:DIV_STEPS];
  logic [LANES-1:0][NUM_W-1:0] dv_rem   [0:DIV_STEPS];
  logic [LANES-1:0][QUO_W-1:0] dv_quo   [0:DIV_STEPS];
  div_side_t                   dv_side  [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= sq_valid[SQRT_STEPS];
    end
    dv_len[0]            <= len;
    dv_quo[0]            <= '0;
    dv_side[0].neg       <= len_side.neg;
    dv_side[0].too_small <= len <= ROOT_W'(min_magnitude);
    for (int i = 0; i < LANES; i++) begin
      dv_rem[0][i] <= {len_side.mag[i], FRAC_SH'(0)} + NUM_W'(len >> 1);
    end
  end

  // division chain, top quotient bit first
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    vn_div_stage #(
      .K (DIV_STEPS - 1 - g)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[g]),
      .in_len    (dv_len[g]),
      .in_rem    (dv_rem[g]),
      .in_quo    (dv_quo[g]),
      .in_side   (dv_side[g]),
      .out_valid (dv_valid[g+1]),
      .out_len   (dv_len[g+1]),
      .out_rem   (dv_rem[g+1]),
      .out_quo   (dv_quo[g+1]),
      .out_side  (dv_side[g+1])
    );
  end

  // output stage: saturate, sign, zero when too small
  logic [LANES-1:0][UNIT_W-1:0] res;
  logic [QUO_W-1:0]             q;
  div_side_t                    fin;

  assign fin = dv_side[DIV_STEPS];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      q      = dv_quo[DIV_STEPS][i];
      res[i] = q[QUO_W-1] ? UNIT_MAX : {1'b0, q[QUO_W-2:0]};
      if (fin.neg[i]) begin
        res[i] = ~res[i] + UNIT_W'(1);
      end
      if (fin.too_small) begin
        res[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[DIV_STEPS];
    end
    unit_x    <= res[0];
    unit_y    <= res[1];
    unit_z    <= res[2];
    too_small <= fin.too_small;
  end

endmodule
`default_nettype wire

>>> rtl/vn_sqrt_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vn_sqrt_stage
// One registered step of the digit-by-digit square root: one root bit a stage.
// ----------------------------------------------------------------------------
module vn_sqrt_stage
  import vn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [SQ_W-1:0]   in_op,
  input  wire logic [REM_W-1:0]  in_rem,
  input  wire logic [ROOT_W-1:0] in_root,
  input  wire sqrt_side_t        in_side,
  output logic                   out_valid,
  output logic [SQ_W-1:0]        out_op,
  output logic [REM_W-1:0]       out_rem,
  output logic [ROOT_W-1:0]      out_root,
  output sqrt_side_t             out_side
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  always_comb begin
    rem_sh = {in_rem[REM_W-3:0], in_op[SQ_W-1:SQ_W-2]};
    trial  = {in_root, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_op   <= {in_op[SQ_W-3:0], 2'b00};
    out_rem  <= fits ? rem_sh - trial : rem_sh;
    out_root <= {in_root[ROOT_W-2:0], fits};
    out_side <= in_side;
  end

endmodule
`default_nettype wire

>>> rtl/vn_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vn_div_stage
// One registered restoring division step for all three lanes at quotient bit K.
// ----------------------------------------------------------------------------
module vn_div_stage
  import vn_pkg::*;
#(
  parameter int K = 0
)
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [ROOT_W-1:0]            in_len,
  input  wire logic [LANES-1:0][NUM_W-1:0]  in_rem,
  input  wire logic [LANES-1:0][QUO_W-1:0]  in_quo,
  input  wire div_side_t                    in_side,
  output logic                              out_valid,
  output logic [ROOT_W-1:0]                 out_len,
  output logic [LANES-1:0][NUM_W-1:0]       out_rem,
  output logic [LANES-1:0][QUO_W-1:0]       out_quo,
  output div_side_t                         out_side
);

  logic [NUM_W-1:0]            dsh;
  logic [LANES-1:0][NUM_W-1:0] rem_next;
  logic [LANES-1:0][QUO_W-1:0] quo_next;

  always_comb begin
    dsh = NUM_W'(in_len) << K;
    for (int i = 0; i < LANES; i++) begin
      rem_next[i] = in_rem[i];
      quo_next[i] = in_quo[i];
      if (in_rem[i] >= dsh) begin
        rem_next[i]    = in_rem[i] - dsh;
        quo_next[i][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_len  <= in_len;
    out_rem  <= rem_next;
    out_quo  <= quo_next;
    out_side <= in_side;
  end

endmodule
`default_nettype wire
